FILE: sv/vbg_pkg.sv
// Shared constants, widths, opcodes, status codes and sequencer states of the voxel bit grid.
package vbg_pkg;

    localparam int AXIS_MAX   = 64;
    localparam int WORD_BITS  = 32;

    localparam int COORD_W    = $clog2(AXIS_MAX);      // one axis coordinate
    localparam int CNT_W      = COORD_W + 1;           // count, holds AXIS_MAX itself
    localparam int MAC_A_W    = 2 * COORD_W;           // y*count_z+z
    localparam int IDX_W      = 3 * COORD_W;           // linear bit index
    localparam int BIT_W      = $clog2(WORD_BITS);     // bit within a word
    localparam int ADDR_W     = IDX_W - BIT_W;         // word address
    localparam int MEM_DEPTH  = 2 ** ADDR_W;
    localparam int CFG_IDX_W  = 2;
    localparam int FACE_W     = 6;
    localparam int PROBE_W    = 3;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_FILL  = 2'd2,
        OP_FACE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OUTSIDE  = 2'd1,
        ST_REVERSED = 2'd2
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_Z = 2'd2;

    // probe order of a face query: the voxel itself, then its six neighbours
    localparam logic [PROBE_W-1:0] PRB_CENTER = 3'd0;
    localparam logic [PROBE_W-1:0] PRB_XM     = 3'd1;
    localparam logic [PROBE_W-1:0] PRB_XP     = 3'd2;
    localparam logic [PROBE_W-1:0] PRB_YM     = 3'd3;
    localparam logic [PROBE_W-1:0] PRB_YP     = 3'd4;
    localparam logic [PROBE_W-1:0] PRB_ZM     = 3'd5;
    localparam logic [PROBE_W-1:0] PRB_ZP     = 3'd6;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_PROBE,
        S_MUL2,
        S_READ,
        S_EVAL,
        S_FRD,
        S_FWR,
        S_FINISH
    } state_t;

endpackage

FILE: sv/vbg_mac.sv
// Shared multiply-add unit with registered result, used for every bit index computation.
module vbg_mac
(
    input  logic                       clk,
    input  logic                       en,
    input  logic [vbg_pkg::MAC_A_W-1:0] a,
    input  logic [vbg_pkg::CNT_W-1:0]   b,
    input  logic [vbg_pkg::CNT_W-1:0]   c,
    output logic [vbg_pkg::IDX_W-1:0]   res
);

    localparam int P_W = vbg_pkg::MAC_A_W + vbg_pkg::CNT_W;

    logic [P_W-1:0] prod;
    logic [P_W-1:0] sum;
    logic [vbg_pkg::IDX_W-1:0] res_reg;

    assign prod = P_W'(a) * P_W'(b);
    assign sum  = prod + P_W'(c);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= sum[vbg_pkg::IDX_W-1:0];
        end
    end

    assign res = res_reg;

endmodule

FILE: sv/voxel_bit_grid_store_top.sv
// Top level of the voxel bit grid: sequencer, word memory and configuration registers.
//
// Usage:
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes count_x,
//   count_y, count_z (index 0..2); cfg_ready is always high, other indexes are
//   dropped. Write counts only while no item is in flight.
//   Input channel (in_valid/in_ready) takes one word: opcode, coordinates,
//   span end and write value. One result word leaves on out_valid/out_ready.
//   Bit index is (y*count_z+z)*count_x+x, one bit per voxel, 32-bit words.
// Sequencing (one item at a time, in_ready high only when idle): read and
//   write compute the bit index, then read the word; a fill reads, then
//   writes, each word touched (at most 3 words); a face query probes the voxel
//   and its in-grid neighbours; out-of-range or reversed requests end at the check.
//   The pacing is set by the one shared multiply-add unit (two passes per
//   bit index) and the single memory port (read, then write, per word).
// Reset: counts go to 0 and a clearing pass writes zero to all 8192 memory
//   words, one per cycle; in_ready stays low until the pass ends.
// Stall: the result sits in an output register; the next item is taken
//   meanwhile, and its result waits in the finish step until the register frees.
module voxel_bit_grid_store_top
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vbg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vbg_pkg::CNT_W-1:0]         cfg_data,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        opcode,
    input  logic [vbg_pkg::COORD_W-1:0]       coord_x,
    input  logic [vbg_pkg::COORD_W-1:0]       coord_y,
    input  logic [vbg_pkg::COORD_W-1:0]       coord_z,
    input  logic [vbg_pkg::COORD_W-1:0]       span_end_x,
    input  logic                              write_value,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              voxel_value,
    output logic [vbg_pkg::FACE_W-1:0]        face_mask,
    output logic [1:0]                        status
);

    localparam int CNT_W   = vbg_pkg::CNT_W;
    localparam int COORD_W = vbg_pkg::COORD_W;
    localparam int IDX_W   = vbg_pkg::IDX_W;
    localparam int BIT_W   = vbg_pkg::BIT_W;
    localparam int ADDR_W  = vbg_pkg::ADDR_W;
    localparam int WB      = vbg_pkg::WORD_BITS;
    localparam int PROBE_W = vbg_pkg::PROBE_W;
    localparam int FACE_W  = vbg_pkg::FACE_W;
    localparam logic [CNT_W-1:0] AXIS_LIM = CNT_W'(vbg_pkg::AXIS_MAX);

    // control state
    vbg_pkg::state_t    state_reg, state_next;
    logic [ADDR_W-1:0]  clr_cnt_reg;
    logic [CNT_W-1:0]   cnt_x_reg, cnt_y_reg, cnt_z_reg;
    logic               out_valid_reg;

    // captured item and working values
    vbg_pkg::opcode_t   op_reg;
    logic [COORD_W-1:0] x_reg, y_reg, z_reg, ex_reg;
    logic               wv_reg;
    logic [PROBE_W-1:0] probe_reg;
    logic               res_value_reg;
    logic [FACE_W-1:0]  res_mask_reg;
    vbg_pkg::status_t   res_status_reg;
    logic [IDX_W-1:0]   s_reg, e_reg;
    logic [ADDR_W-1:0]  wa_reg;

    logic               out_value_reg;
    logic [FACE_W-1:0]  out_mask_reg;
    logic [1:0]         out_status_reg;

    // memory
    logic [WB-1:0]      mem [vbg_pkg::MEM_DEPTH];
    logic [WB-1:0]      rd_reg;
    logic               mem_we, mem_re;
    logic [ADDR_W-1:0]  mem_addr;
    logic [WB-1:0]      mem_wdata;

    // shared multiply-add
    logic                        mac_en;
    logic [vbg_pkg::MAC_A_W-1:0] mac_a;
    logic [CNT_W-1:0]            mac_b, mac_c;
    logic [IDX_W-1:0]            mac_res;

    logic [CNT_W-1:0]   eff_x, eff_y, eff_z;
    logic               ctr_in, end_in;
    vbg_pkg::status_t   chk_status;
    logic [CNT_W-1:0]   px, py, pz;
    logic               pneg, probe_in;
    logic               cur_bit;
    logic [WB-1:0]      bit_sel;
    logic [BIT_W-1:0]   fill_lo, fill_hi;
    logic [WB-1:0]      fill_mask;
    logic               in_acc, out_load, last_probe;

    vbg_mac u_mac
    (
        .clk (clk),
        .en  (mac_en),
        .a   (mac_a),
        .b   (mac_b),
        .c   (mac_c),
        .res (mac_res)
    );

    // counts above the grid size act as the grid size
    assign eff_x = (cnt_x_reg > AXIS_LIM) ? AXIS_LIM : cnt_x_reg;
    assign eff_y = (cnt_y_reg > AXIS_LIM) ? AXIS_LIM : cnt_y_reg;
    assign eff_z = (cnt_z_reg > AXIS_LIM) ? AXIS_LIM : cnt_z_reg;

    assign ctr_in = (CNT_W'(x_reg) < eff_x) && (CNT_W'(y_reg) < eff_y) &&
                    (CNT_W'(z_reg) < eff_z);
    assign end_in = CNT_W'(ex_reg) < eff_x;

    always_comb
    begin
        chk_status = vbg_pkg::ST_OK;
        if (op_reg == vbg_pkg::OP_FILL)
        begin
            if (!(ctr_in && end_in))
            begin
                chk_status = vbg_pkg::ST_OUTSIDE;
            end
            else if (ex_reg < x_reg)
            begin
                chk_status = vbg_pkg::ST_REVERSED;
            end
        end
        else if (!ctr_in)
        begin
            chk_status = vbg_pkg::ST_OUTSIDE;
        end
    end

    // coordinates of the current probe; a step below zero is flagged
    always_comb
    begin
        px   = CNT_W'(x_reg);
        py   = CNT_W'(y_reg);
        pz   = CNT_W'(z_reg);
        pneg = 1'b0;
        case (probe_reg)
            vbg_pkg::PRB_CENTER: ;
            vbg_pkg::PRB_XM:
            begin
                px   = CNT_W'(x_reg) - CNT_W'(1);
                pneg = (x_reg == '0);
            end
            vbg_pkg::PRB_XP: px = CNT_W'(x_reg) + CNT_W'(1);
            vbg_pkg::PRB_YM:
            begin
                py   = CNT_W'(y_reg) - CNT_W'(1);
                pneg = (y_reg == '0);
            end
            vbg_pkg::PRB_YP: py = CNT_W'(y_reg) + CNT_W'(1);
            vbg_pkg::PRB_ZM:
            begin
                pz   = CNT_W'(z_reg) - CNT_W'(1);
                pneg = (z_reg == '0);
            end
            vbg_pkg::PRB_ZP: pz = CNT_W'(z_reg) + CNT_W'(1);
            default: pneg = 1'b1;
        endcase
    end

    assign probe_in   = !pneg && (px < eff_x) && (py < eff_y) && (pz < eff_z);
    assign last_probe = (probe_reg == vbg_pkg::PRB_ZP);

    assign cur_bit = rd_reg[mac_res[BIT_W-1:0]];
    assign bit_sel = WB'(1) << mac_res[BIT_W-1:0];

    // span bits inside the current word
    assign fill_lo   = (wa_reg == s_reg[IDX_W-1:BIT_W]) ? s_reg[BIT_W-1:0] : '0;
    assign fill_hi   = (wa_reg == e_reg[IDX_W-1:BIT_W]) ? e_reg[BIT_W-1:0] : '1;
    assign fill_mask = ({WB{1'b1}} << fill_lo) &
                       ({WB{1'b1}} >> (BIT_W'(WB - 1) - fill_hi));

    assign in_acc = in_valid && in_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vbg_pkg::S_CLEAR:
                if (clr_cnt_reg == ADDR_W'(vbg_pkg::MEM_DEPTH - 1))
                begin
                    state_next = vbg_pkg::S_IDLE;
                end
            vbg_pkg::S_IDLE:
                if (in_valid)
                begin
                    state_next = vbg_pkg::S_CHECK;
                end
            vbg_pkg::S_CHECK:
                state_next = (chk_status != vbg_pkg::ST_OK) ? vbg_pkg::S_FINISH
                                                           : vbg_pkg::S_PROBE;
            vbg_pkg::S_PROBE:
                if (probe_in)
                begin
                    state_next = vbg_pkg::S_MUL2;
                end
                else if (last_probe)
                begin
                    state_next = vbg_pkg::S_FINISH;
                end
            vbg_pkg::S_MUL2:
                state_next = vbg_pkg::S_READ;
            vbg_pkg::S_READ:
                state_next = (op_reg == vbg_pkg::OP_FILL) ? vbg_pkg::S_FRD
                                                          : vbg_pkg::S_EVAL;
            vbg_pkg::S_EVAL:
                if (op_reg != vbg_pkg::OP_FACE || last_probe ||
                    (probe_reg == vbg_pkg::PRB_CENTER && !cur_bit))
                begin
                    state_next = vbg_pkg::S_FINISH;
                end
                else
                begin
                    state_next = vbg_pkg::S_PROBE;
                end
            vbg_pkg::S_FRD:
                state_next = vbg_pkg::S_FWR;
            vbg_pkg::S_FWR:
                if (wa_reg == e_reg[IDX_W-1:BIT_W])
                begin
                    state_next = vbg_pkg::S_FINISH;
                end
                else
                begin
                    state_next = vbg_pkg::S_FRD;
                end
            vbg_pkg::S_FINISH:
                if (!out_valid_reg || out_ready)
                begin
                    state_next = vbg_pkg::S_IDLE;
                end
            default:
                state_next = vbg_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = mac_res[IDX_W-1:BIT_W];
        mem_wdata = rd_reg;
        mac_en    = 1'b0;
        mac_a     = vbg_pkg::MAC_A_W'(py);
        mac_b     = eff_z;
        mac_c     = pz;
        out_load  = 1'b0;
        case (state_reg)
            vbg_pkg::S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_cnt_reg;
                mem_wdata = '0;
            end
            vbg_pkg::S_PROBE:
                mac_en = probe_in;
            vbg_pkg::S_MUL2:
            begin
                mac_en = 1'b1;
                mac_a  = mac_res[vbg_pkg::MAC_A_W-1:0];
                mac_b  = eff_x;
                mac_c  = px;
            end
            vbg_pkg::S_READ:
                mem_re = (op_reg != vbg_pkg::OP_FILL);
            vbg_pkg::S_EVAL:
                if (op_reg == vbg_pkg::OP_WRITE)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = wv_reg ? (rd_reg | bit_sel) : (rd_reg & ~bit_sel);
                end
            vbg_pkg::S_FRD:
            begin
                mem_re   = 1'b1;
                mem_addr = wa_reg;
            end
            vbg_pkg::S_FWR:
            begin
                mem_we    = 1'b1;
                mem_addr  = wa_reg;
                mem_wdata = wv_reg ? (rd_reg | fill_mask) : (rd_reg & ~fill_mask);
            end
            vbg_pkg::S_FINISH:
                out_load = !out_valid_reg || out_ready;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_reg <= mem[mem_addr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vbg_pkg::S_CLEAR;
            clr_cnt_reg   <= '0;
            cnt_x_reg     <= '0;
            cnt_y_reg     <= '0;
            cnt_z_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == vbg_pkg::S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    vbg_pkg::CFG_COUNT_X: cnt_x_reg <= cfg_data;
                    vbg_pkg::CFG_COUNT_Y: cnt_y_reg <= cfg_data;
                    vbg_pkg::CFG_COUNT_Z: cnt_z_reg <= cfg_data;
                    default: ;
                endcase
            end
            out_valid_reg <= out_load || (out_valid_reg && !out_ready);
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg         <= vbg_pkg::opcode_t'(opcode);
            x_reg          <= coord_x;
            y_reg          <= coord_y;
            z_reg          <= coord_z;
            ex_reg         <= span_end_x;
            wv_reg         <= write_value;
            res_value_reg  <= 1'b0;
            res_mask_reg   <= '0;
            res_status_reg <= vbg_pkg::ST_OK;
        end
        case (state_reg)
            vbg_pkg::S_CHECK:
            begin
                res_status_reg <= chk_status;
                probe_reg      <= vbg_pkg::PRB_CENTER;
            end
            vbg_pkg::S_PROBE:
                // neighbour outside the grid counts as empty
                if (!probe_in)
                begin
                    res_mask_reg[PROBE_W'(probe_reg - PROBE_W'(1))] <= 1'b1;
                    probe_reg <= probe_reg + PROBE_W'(1);
                end
            vbg_pkg::S_READ:
                if (op_reg == vbg_pkg::OP_FILL)
                begin
                    s_reg  <= mac_res;
                    e_reg  <= mac_res + IDX_W'(ex_reg - x_reg);
                    wa_reg <= mac_res[IDX_W-1:BIT_W];
                end
            vbg_pkg::S_EVAL:
                case (op_reg)
                    vbg_pkg::OP_READ:  res_value_reg <= cur_bit;
                    vbg_pkg::OP_WRITE: res_value_reg <= wv_reg;
                    vbg_pkg::OP_FACE:
                    begin
                        if (probe_reg == vbg_pkg::PRB_CENTER)
                        begin
                            res_value_reg <= cur_bit;
                        end
                        else if (!cur_bit)
                        begin
                            res_mask_reg[PROBE_W'(probe_reg - PROBE_W'(1))] <= 1'b1;
                        end
                        probe_reg <= probe_reg + PROBE_W'(1);
                    end
                    default: ;
                endcase
            vbg_pkg::S_FWR:
                wa_reg <= wa_reg + ADDR_W'(1);
            default: ;
        endcase
        if (out_load)
        begin
            out_value_reg  <= res_value_reg;
            out_mask_reg   <= res_mask_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign cfg_ready   = 1'b1;
    assign in_ready    = (state_reg == vbg_pkg::S_IDLE);
    assign out_valid   = out_valid_reg;
    assign voxel_value = out_value_reg;
    assign face_mask   = out_mask_reg;
    assign status      = out_status_reg;

endmodule

FILE: bench/tb.sv
// Self-checking bench for the voxel bit grid: directed table, then random phases of count settings.
module tb;
    import vbg_pkg::*;

    // ------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------
    localparam int GRID_CELLS    = AXIS_MAX * AXIS_MAX * AXIS_MAX;
    localparam int STALL_LIMIT   = 40000;   // covers the clearing pass of all 8192 words several times
    localparam int SETTLE_CYCLES = 4;       // idle gap before a count write
    localparam int TAIL_CYCLES   = 64;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_WORDS   = 215;
    localparam int EMPTY_WORDS   = 60;      // a zero count turns every word into an outside case

    // index 3 is not a register; the block must drop writes to it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // one result word: stored bit, exposure mask, status
    typedef struct packed {
        logic              voxel;
        logic [FACE_W-1:0] faces;
        status_t           st;
    } grid_result_t;

    // one line of the directed plan: either a count batch or an input word
    typedef struct packed {
        bit                 is_cfg;
        bit                 poke_spare;
        logic [CNT_W-1:0]   cx;
        logic [CNT_W-1:0]   cy;
        logic [CNT_W-1:0]   cz;
        opcode_t            op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [COORD_W-1:0] ex;
        logic               wv;
        bit                 typed;
        grid_result_t       want;
    } plan_row_t;

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CNT_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    opcode_t              opcode;
    logic [COORD_W-1:0]   coord_x;
    logic [COORD_W-1:0]   coord_y;
    logic [COORD_W-1:0]   coord_z;
    logic [COORD_W-1:0]   span_end_x;
    logic                 write_value;
    logic                 out_valid;
    logic                 out_ready;
    logic                 voxel_value;
    logic [FACE_W-1:0]    face_mask;
    logic [1:0]           status;

    voxel_bit_grid_store_top dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .span_end_x  (span_end_x),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .voxel_value (voxel_value),
        .face_mask   (face_mask),
        .status      (status)
    );

    // ------------------------------------------------------------------
    // Shadow grid: the bench's own copy of every voxel bit and the
    // effective (saturated) counts, kept in step with accepted words.
    // ------------------------------------------------------------------
    bit          grid_bits [GRID_CELLS];
    int unsigned dim_x, dim_y, dim_z;

    grid_result_t expected_results [$];   // oldest expectation at the front
    plan_row_t    plan [$];

    // side info that travels with the input word (driven with the payload)
    bit           row_typed;
    grid_result_t row_expect;

    int unsigned words_sent;
    int unsigned results_seen;
    int unsigned errors;
    int unsigned settings_used;
    int unsigned op_tally [4];
    int unsigned stall_cycles;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    // generator view of the current layout and the window it favors
    int unsigned gen_x, gen_y, gen_z;
    int unsigned anchor_x, anchor_y, anchor_z;

    // counts above AXIS_MAX behave as AXIS_MAX
    function automatic int unsigned axis_span(logic [CNT_W-1:0] c);
        return (c > AXIS_MAX) ? AXIS_MAX : int'(c);
    endfunction

    function automatic bit cell_in(int x, int y, int z);
        return x >= 0 && y >= 0 && z >= 0 &&
               x < int'(dim_x) && y < int'(dim_y) && z < int'(dim_z);
    endfunction

    function automatic int cell_index(int x, int y, int z);
        return (y * int'(dim_z) + z) * int'(dim_x) + x;
    endfunction

    // neighbours outside the grid read as empty
    function automatic bit cell_bit(int x, int y, int z);
        return cell_in(x, y, z) ? grid_bits[cell_index(x, y, z)] : 1'b0;
    endfunction

    // Works out the result word of one input word and updates the shadow grid.
    function automatic grid_result_t apply_grid_op(opcode_t op, int x, int y, int z,
                                                   int ex, logic wv);
        grid_result_t res;
        int           base;
        res.voxel = 1'b0;
        res.faces = '0;
        res.st    = ST_OK;
        if (op == OP_FILL)
        begin
            // range check on both ends comes before the order check
            if (!cell_in(x, y, z) || !cell_in(ex, y, z))
                res.st = ST_OUTSIDE;
            else if (ex < x)
                res.st = ST_REVERSED;
            else
            begin
                base = cell_index(0, y, z);
                for (int i = x; i <= ex; i++)
                    grid_bits[base + i] = wv;
            end
        end
        else if (!cell_in(x, y, z))
            res.st = ST_OUTSIDE;
        else if (op == OP_READ)
            res.voxel = cell_bit(x, y, z);
        else if (op == OP_WRITE)
        begin
            grid_bits[cell_index(x, y, z)] = wv;
            res.voxel = wv;
        end
        else
        begin
            res.voxel = cell_bit(x, y, z);
            // mask only for a set voxel: x-, x+, y-, y+, z-, z+ from bit 0 up
            if (res.voxel)
            begin
                res.faces[0] = !cell_bit(x - 1, y, z);
                res.faces[1] = !cell_bit(x + 1, y, z);
                res.faces[2] = !cell_bit(x, y - 1, z);
                res.faces[3] = !cell_bit(x, y + 1, z);
                res.faces[4] = !cell_bit(x, y, z - 1);
                res.faces[5] = !cell_bit(x, y, z + 1);
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Plan row builders
    // ------------------------------------------------------------------
    function automatic plan_row_t cfg_row(logic [CNT_W-1:0] cx, cy, cz, bit poke);
        plan_row_t r;
        r            = '0;
        r.is_cfg     = 1'b1;
        r.poke_spare = poke;
        r.cx         = cx;
        r.cy         = cy;
        r.cz         = cz;
        return r;
    endfunction

    function automatic plan_row_t op_row(opcode_t op, logic [COORD_W-1:0] x, y, z, ex,
                                         logic wv);
        plan_row_t r;
        r    = '0;
        r.op = op;
        r.x  = x;
        r.y  = y;
        r.z  = z;
        r.ex = ex;
        r.wv = wv;
        return r;
    endfunction

    // row whose result is typed in rather than predicted
    function automatic plan_row_t checked_row(opcode_t op, logic [COORD_W-1:0] x, y, z, ex,
                                              logic wv, logic val, logic [FACE_W-1:0] faces,
                                              status_t st);
        plan_row_t r;
        r             = op_row(op, x, y, z, ex, wv);
        r.typed       = 1'b1;
        r.want.voxel  = val;
        r.want.faces  = faces;
        r.want.st     = st;
        return r;
    endfunction

    // appends one row at the end of the directed plan
    function automatic void add_row(plan_row_t r);
        plan.insert(plan.size(), r);
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: out_ready drops at random per the current idle share.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge, so it sees the
    // values that were settled before the edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        grid_result_t want;
        if (rst_n)
        begin
            // results first, so a stray word is not matched with the
            // expectation queued at this same edge
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result word: voxel_value %0b face_mask %b status %0d",
                             $time, voxel_value, face_mask, status);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (voxel_value !== want.voxel)
                    begin
                        $display("%0t: voxel_value expected %0b got %0b",
                                 $time, want.voxel, voxel_value);
                        errors++;
                    end
                    if (face_mask !== want.faces)
                    begin
                        $display("%0t: face_mask expected %b got %b",
                                 $time, want.faces, face_mask);
                        errors++;
                    end
                    if (status !== want.st)
                    begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.st, status);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                // predictor always runs so the shadow grid stays current
                want = apply_grid_op(opcode, coord_x, coord_y, coord_z, span_end_x,
                                     write_value);
                if (row_typed)
                    want = row_expect;
                expected_results.insert(expected_results.size(), want);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_COUNT_X: dim_x = axis_span(cfg_data);
                    CFG_COUNT_Y: dim_y = axis_span(cfg_data);
                    CFG_COUNT_Z: dim_z = axis_span(cfg_data);
                    default: ;
                endcase
            end
        end
    end

    // Watchdog: too long with no word moving on any channel ends the run.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no traffic for %0d cycles, %0d results still due",
                     $time, STALL_LIMIT, words_sent - results_seen);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------

    // Offers one input word; returns at the edge that accepted it with
    // in_valid still high, so back-to-back words need no extra step.
    task automatic send_word(opcode_t op, logic [COORD_W-1:0] x, y, z, ex, logic wv,
                             bit typed, grid_result_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        coord_x     <= x;
        coord_y     <= y;
        coord_z     <= z;
        span_end_x  <= ex;
        write_value <= wv;
        row_typed   <= typed;
        row_expect  <= want;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
        op_tally[op]++;
    endtask

    // Stops offering words, waits for every due result, then lets the block settle.
    task automatic drain_results(int unsigned settle);
        in_valid <= 1'b0;
        while (results_seen < words_sent)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Writes the three counts back to back; optionally pokes the unused index.
    task automatic program_counts(logic [CNT_W-1:0] cx, cy, cz, bit poke);
        logic [CFG_IDX_W-1:0] idx  [4];
        logic [CNT_W-1:0]     vals [4];
        int                   n;
        idx  = '{CFG_COUNT_X, CFG_COUNT_Y, CFG_COUNT_Z, CFG_SPARE};
        vals = '{cx, cy, cz, 7'd5};
        n    = poke ? 4 : 3;
        for (int i = 0; i < n; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        gen_x = axis_span(cx);
        gen_y = axis_span(cy);
        gen_z = axis_span(cz);
        settings_used++;
    endtask

    // anchor of a small window, so random words land near each other
    function automatic int unsigned pick_anchor(int unsigned span);
        return (span > 6) ? $urandom_range(span - 6) : 0;
    endfunction

    // mostly inside the window, sometimes anywhere in the grid, rarely anywhere at all
    function automatic logic [COORD_W-1:0] pick_axis(int unsigned span, int unsigned anchor);
        int unsigned r;
        int unsigned win;
        r   = $urandom_range(99);
        win = (span < 6) ? span : 6;
        if (span == 0 || r >= 90)
            return COORD_W'($urandom_range(AXIS_MAX - 1));
        if (r >= 70)
            return COORD_W'($urandom_range(span - 1));
        return COORD_W'(anchor + $urandom_range(win - 1));
    endfunction

    task automatic random_word();
        opcode_t            op;
        logic [COORD_W-1:0] x, y, z, ex, t;
        logic               wv;
        int unsigned        r;
        r  = $urandom_range(99);
        op = (r < 25) ? OP_READ : (r < 55) ? OP_WRITE : (r < 75) ? OP_FILL : OP_FACE;
        x  = pick_axis(gen_x, anchor_x);
        y  = pick_axis(gen_y, anchor_y);
        z  = pick_axis(gen_z, anchor_z);
        if (op == OP_FILL)
        begin
            // some fills pick both ends anywhere in the row to cross word boundaries
            if (gen_x > 0 && $urandom_range(99) < 30)
            begin
                x  = COORD_W'($urandom_range(gen_x - 1));
                ex = COORD_W'($urandom_range(gen_x - 1));
            end
            else
                ex = pick_axis(gen_x, anchor_x);
            if (ex < x && $urandom_range(99) < 80)
            begin
                t  = x;
                x  = ex;
                ex = t;
            end
        end
        else
            ex = COORD_W'($urandom_range(AXIS_MAX - 1));
        // lean toward setting bits so face queries find solid regions
        wv = ($urandom_range(99) < 70);
        send_word(op, x, y, z, ex, wv, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        plan_row_t        row;
        logic [CNT_W-1:0] phase_counts [NUM_PHASES][3];
        int unsigned      phase_len;
        int unsigned      done;

        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_COUNT_X;
        cfg_data      = '0;
        in_valid      = 1'b0;
        opcode        = OP_READ;
        coord_x       = '0;
        coord_y       = '0;
        coord_z       = '0;
        span_end_x    = '0;
        write_value   = 1'b0;
        out_ready     = 1'b0;
        row_typed     = 1'b0;
        row_expect    = '0;
        words_sent    = 0;
        results_seen  = 0;
        errors        = 0;
        settings_used = 0;
        op_tally      = '{0, 0, 0, 0};
        stall_cycles  = 0;
        dim_x         = 0;
        dim_y         = 0;
        dim_z         = 0;
        gen_x         = 0;
        gen_y         = 0;
        gen_z         = 0;
        send_idle_pct = 37;
        recv_idle_pct = 48;
        done          = 0;

        // count settings per random phase; the last one is drawn at run time
        phase_counts = '{'{7'd4,   7'd4,  7'd4},
                         '{7'd64,  7'd64, 7'd64},
                         '{7'd37,  7'd5,  7'd3},
                         '{7'd1,   7'd64, 7'd1},
                         '{7'd127, 7'd2,  7'd9},
                         '{7'd0,   7'd6,  7'd6},
                         '{7'd8,   7'd8,  7'd2},
                         '{7'd0,   7'd0,  7'd0}};

        // Directed plan. Counts are zero right after reset, so the first
        // word must come back as outside the grid.
        add_row(checked_row(OP_READ, 0, 0, 0, 0, 0, 0, '0, ST_OUTSIDE));
        // counts above the axis limit saturate; the spare index must be dropped
        add_row(cfg_row(7'd127, 7'd127, 7'd127, 1'b1));
        add_row(checked_row(OP_READ, 63, 63, 63, 0, 0, 0, '0, ST_OK));
        add_row(checked_row(OP_WRITE, 63, 63, 63, 0, 1, 1, '0, ST_OK));
        // far corner: three neighbours empty, three beyond the edge
        add_row(checked_row(OP_FACE, 63, 63, 63, 0, 0, 1, 6'b111111, ST_OK));
        // full-width row: two whole words
        add_row(checked_row(OP_FILL, 0, 0, 0, 63, 1, 0, '0, ST_OK));
        add_row(checked_row(OP_FACE, 5, 0, 0, 0, 0, 1, 6'b111100, ST_OK));
        add_row(checked_row(OP_FILL, 40, 0, 0, 10, 1, 0, '0, ST_REVERSED));
        add_row(checked_row(OP_READ, 0, 0, 0, 0, 0, 1, '0, ST_OK));
        add_row(checked_row(OP_WRITE, 0, 0, 0, 0, 0, 0, '0, ST_OK));
        // face query on a clear voxel gives no mask
        add_row(checked_row(OP_FACE, 0, 0, 0, 0, 0, 0, '0, ST_OK));
        add_row(checked_row(OP_FACE, 1, 0, 0, 0, 0, 1, 6'b111101, ST_OK));
        // unaligned clear across a word boundary
        add_row(op_row(OP_FILL, 7, 0, 0, 38, 0));
        add_row(op_row(OP_FACE, 6, 0, 0, 0, 0));
        // new layout over the same stored bits
        add_row(cfg_row(7'd5, 7'd3, 7'd4, 1'b0));
        add_row(op_row(OP_READ, 1, 0, 0, 0, 0));
        add_row(checked_row(OP_WRITE, 5, 0, 0, 0, 1, 0, '0, ST_OUTSIDE));
        add_row(checked_row(OP_READ, 0, 3, 0, 0, 0, 0, '0, ST_OUTSIDE));
        add_row(checked_row(OP_FACE, 0, 0, 4, 0, 0, 0, '0, ST_OUTSIDE));
        add_row(checked_row(OP_FILL, 2, 0, 0, 5, 1, 0, '0, ST_OUTSIDE));
        add_row(checked_row(OP_FILL, 4, 0, 0, 1, 1, 0, '0, ST_REVERSED));
        // start beyond the edge and reversed: range check wins
        add_row(checked_row(OP_FILL, 6, 0, 0, 2, 1, 0, '0, ST_OUTSIDE));
        add_row(op_row(OP_FILL, 0, 2, 3, 4, 1));
        add_row(op_row(OP_FACE, 2, 2, 3, 0, 0));
        // single-voxel grid: every neighbour is beyond the edge
        add_row(cfg_row(7'd1, 7'd1, 7'd1, 1'b0));
        add_row(checked_row(OP_WRITE, 0, 0, 0, 0, 1, 1, '0, ST_OK));
        add_row(checked_row(OP_FACE, 0, 0, 0, 0, 0, 1, 6'b111111, ST_OK));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            row = plan[i];
            if (row.is_cfg)
            begin
                drain_results(SETTLE_CYCLES);
                program_counts(row.cx, row.cy, row.cz, row.poke_spare);
            end
            else
                send_word(row.op, row.x, row.y, row.z, row.ex, row.wv, row.typed, row.want);
        end

        // Random phases, one count setting each. Idle shares follow the
        // schedule: receiver-heavy, then sender-heavy, then none at all.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p == NUM_PHASES - 1)
                phase_counts[p] = '{CNT_W'($urandom_range(16, 1)),
                                    CNT_W'($urandom_range(16, 1)),
                                    CNT_W'($urandom_range(16, 1))};
            drain_results(SETTLE_CYCLES);
            program_counts(phase_counts[p][0], phase_counts[p][1], phase_counts[p][2], 1'b0);
            anchor_x  = pick_anchor(gen_x);
            anchor_y  = pick_anchor(gen_y);
            anchor_z  = pick_anchor(gen_z);
            phase_len = (gen_x * gen_y * gen_z == 0) ? EMPTY_WORDS : PHASE_WORDS;
            for (int k = 0; k < phase_len; k++)
            begin
                if (done < 520)
                begin
                    send_idle_pct = 37;
                    recv_idle_pct = 48;
                end
                else if (done < 1040)
                begin
                    send_idle_pct = 48;
                    recv_idle_pct = 37;
                end
                else
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                random_word();
                done++;
            end
        end

        drain_results(TAIL_CYCLES);
        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d expected result words never arrived",
                     $time, expected_results.size());
            errors++;
        end

        $display("Sent %0d words: %0d reads, %0d writes, %0d span fills, %0d face queries",
                 words_sent, op_tally[OP_READ], op_tally[OP_WRITE], op_tally[OP_FILL],
                 op_tally[OP_FACE]);
        $display("%0d count settings, %0d results compared, %0d mismatches",
                 settings_used, results_seen, errors);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
